### sv/run_blob_bounding_box_tracker_top_defines.svh
// Assertion macros used by the blob tracker datapath.
`ifndef RUN_BLOB_BOUNDING_BOX_TRACKER_TOP_DEFINES_SVH
`define RUN_BLOB_BOUNDING_BOX_TRACKER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define RBBT_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define RBBT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/rbbt_pkg.sv
// Types and constants shared by the blob tracker modules.
package rbbt_pkg;

	localparam int SLOTS      = 32;
	localparam int COORD_BITS = 12;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [SLOTS-1:0]      slot_vec_t;

	typedef enum logic [1:0] {
		OP_RUN    = 2'd0,
		OP_FINISH = 2'd1,
		OP_FRAME  = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		ST_BOX       = 2'd0,
		ST_ROW_EMPTY = 2'd1,
		ST_DROP      = 2'd2
	} status_t;

	typedef struct packed {
		opcode_t opcode;
		coord_t  row;
		coord_t  col_start;
		coord_t  col_end;
	} req_t;

	typedef struct packed {
		status_t status;
		coord_t  box_x;
		coord_t  box_y;
		coord_t  box_width;
		coord_t  box_height;
		logic    last;
	} res_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic frame;
		logic run_cmp;
		logic run_upd;
		logic fin_load;
		logic fin_emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic more;
	} sts_t;

endpackage

### sv/run_blob_bounding_box_tracker_top.sv
// Top level of the run-length blob bounding-box tracker.
// Usage: drive request and raise start; a transaction is taken at the clock edge
// where start is high and busy is low. opcode selects a run (0), a finished row (1)
// or a new frame (2); opcode 3 is taken and ignored.
// Results leave on result, each valid for exactly one cycle while result_strobe is
// high; result.last marks the final result of a transaction. The receiver cannot
// stall, so results are never held back.
// Sequencing: a run occupies the block through accept, slot compare and slot update;
// a dropped run shows its status result in the cycle after the slot update. A
// finished row loads the closing slots after acceptance, then emits its closed boxes
// (or a single row-empty result if none closes), one per cycle in slot order. A new
// frame completes in its accept cycle. The run compare tests all slots in parallel,
// and the close sequencer emits one box per cycle over the 32-entry slot table.
// Reset: all slots are freed and any pending output is discarded; the block is idle
// and ready to accept once arst_n is released.
module run_blob_bounding_box_tracker_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  rbbt_pkg::req_t request,
	output rbbt_pkg::res_t result,
	output logic           result_strobe
);

	rbbt_pkg::cmd_t cmd;
	rbbt_pkg::sts_t sts;

	// Sequencing of each transaction.
	rbbt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (request.opcode),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	// Slot table and result path.
	rbbt_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.request       (request),
		.cmd           (cmd),
		.sts           (sts),
		.result        (result),
		.result_strobe (result_strobe)
	);

endmodule

### sv/rbbt_ctrl.sv
// Controller state machine of the blob tracker.
module rbbt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  rbbt_pkg::opcode_t opcode,
	input  rbbt_pkg::sts_t    sts,
	output logic              busy,
	output rbbt_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RUN_CMP,
		S_RUN_UPD,
		S_FIN_LOAD,
		S_FIN_EMIT
	} state_t;

	state_t state_q;
	logic   accept;

	// A transaction is taken only while idle.
	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	// Command decode from the current state.
	always_comb begin
		cmd          = '0;
		cmd.load     = accept;
		cmd.frame    = accept && (opcode == rbbt_pkg::OP_FRAME);
		cmd.run_cmp  = (state_q == S_RUN_CMP);
		cmd.run_upd  = (state_q == S_RUN_UPD);
		cmd.fin_load = (state_q == S_FIN_LOAD);
		cmd.fin_emit = (state_q == S_FIN_EMIT);
	end

	// State register. A new frame and the unused opcode finish in the accept cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (opcode)
							rbbt_pkg::OP_RUN:    state_q <= S_RUN_CMP;
							rbbt_pkg::OP_FINISH: state_q <= S_FIN_LOAD;
							default:             state_q <= S_IDLE;
						endcase
					end
				end
				S_RUN_CMP:  state_q <= S_RUN_UPD;
				S_RUN_UPD:  state_q <= S_IDLE;
				S_FIN_LOAD: state_q <= S_FIN_EMIT;
				S_FIN_EMIT: begin
					if (!sts.more) begin
						state_q <= S_IDLE;
					end
				end
				default:    state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### sv/rbbt_datapath.sv
// Slot table, run comparison and box output datapath of the blob tracker.
`include "run_blob_bounding_box_tracker_top_defines.svh"

module rbbt_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  rbbt_pkg::req_t    request,
	input  rbbt_pkg::cmd_t    cmd,
	output rbbt_pkg::sts_t    sts,
	output rbbt_pkg::res_t    result,
	output logic              result_strobe
);

	rbbt_pkg::req_t      req_q;
	rbbt_pkg::slot_vec_t live_q;
	rbbt_pkg::slot_vec_t seen_q;
	rbbt_pkg::slot_vec_t hit_s1;
	rbbt_pkg::slot_vec_t pend_q;
	rbbt_pkg::coord_t    first_row_q [rbbt_pkg::SLOTS];
	rbbt_pkg::coord_t    left_q      [rbbt_pkg::SLOTS];
	rbbt_pkg::coord_t    right_q     [rbbt_pkg::SLOTS];
	rbbt_pkg::res_t      res_q;
	logic                strobe_q;

	rbbt_pkg::slot_vec_t hit_vec;
	rbbt_pkg::slot_vec_t free_vec;
	rbbt_pkg::slot_vec_t free_oh;
	rbbt_pkg::slot_vec_t pend_oh;
	rbbt_pkg::slot_vec_t pend_rest;
	rbbt_pkg::coord_t    sel_first;
	rbbt_pkg::coord_t    sel_left;
	rbbt_pkg::coord_t    sel_right;
	logic                any_hit;
	logic                any_free;
	logic                drop;
	rbbt_pkg::res_t      box;

	// Overlap test of the latched run against every live slot in parallel.
	always_comb begin
		for (int i = 0; i < rbbt_pkg::SLOTS; i++) begin
			hit_vec[i] = live_q[i] &&
				!((left_q[i] > req_q.col_end) || (right_q[i] < req_q.col_start));
		end
	end

	// Lowest free slot and lowest pending slot, both as one-hot vectors.
	assign free_vec  = ~live_q;
	assign free_oh   = free_vec & (~free_vec + rbbt_pkg::SLOTS'(1));
	assign pend_oh   = pend_q & (~pend_q + rbbt_pkg::SLOTS'(1));
	assign pend_rest = pend_q & ~pend_oh;
	assign any_hit   = |hit_s1;
	assign any_free  = |free_vec;
	assign drop      = cmd.run_upd && !any_hit && !any_free;
	assign sts.more  = |pend_rest;

	// Select the data of the slot being closed.
	always_comb begin
		sel_first = '0;
		sel_left  = '0;
		sel_right = '0;
		for (int i = 0; i < rbbt_pkg::SLOTS; i++) begin
			if (pend_oh[i]) begin
				sel_first = sel_first | first_row_q[i];
				sel_left  = sel_left  | left_q[i];
				sel_right = sel_right | right_q[i];
			end
		end
	end

	// Box or empty-row result for the current close step.
	always_comb begin
		box = '0;
		if (pend_q == '0) begin
			box.status = rbbt_pkg::ST_ROW_EMPTY;
			box.last   = 1'b1;
		end else begin
			box.status     = rbbt_pkg::ST_BOX;
			box.box_x      = sel_left;
			box.box_y      = sel_first;
			box.box_width  = (sel_right >= sel_left) ? (sel_right - sel_left) : '0;
			box.box_height = (req_q.row >= sel_first) ? (req_q.row - sel_first) : '0;
			box.last       = !sts.more;
		end
	end

	// Request latch, overlap register and slot coordinates.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= request;
		end
		if (cmd.run_cmp) begin
			hit_s1 <= hit_vec;
		end
		for (int i = 0; i < rbbt_pkg::SLOTS; i++) begin
			if (cmd.run_upd) begin
				if (any_hit) begin
					if (hit_s1[i] && (left_q[i] > req_q.col_start)) begin
						left_q[i] <= req_q.col_start;
					end
					if (hit_s1[i] && (right_q[i] < req_q.col_end)) begin
						right_q[i] <= req_q.col_end;
					end
				end else if (free_oh[i]) begin
					first_row_q[i] <= req_q.row;
					left_q[i]      <= req_q.col_start;
					right_q[i]     <= req_q.col_end;
				end
			end
		end
	end

	// Live, seen and pending flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
			seen_q <= '0;
			pend_q <= '0;
		end else begin
			if (cmd.frame) begin
				live_q <= '0;
				seen_q <= '0;
			end else if (cmd.run_upd) begin
				if (any_hit) begin
					seen_q <= seen_q | hit_s1;
				end else begin
					live_q <= live_q | free_oh;
					seen_q <= seen_q | free_oh;
				end
			end else if (cmd.fin_load) begin
				// Unseen live slots close now; their data stays readable while emitted.
				pend_q <= live_q & ~seen_q;
				live_q <= live_q & seen_q;
				seen_q <= '0;
			end else if (cmd.fin_emit) begin
				pend_q <= pend_rest;
			end
		end
	end

	// Result register, shown for one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.fin_emit || drop;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin_emit) begin
			res_q <= box;
		end else if (drop) begin
			res_q <= '{status: rbbt_pkg::ST_DROP, last: 1'b1, default: '0};
		end
	end

	assign result        = res_q;
	assign result_strobe = strobe_q;

	`RBBT_ASSERT_IMPL(a_seen_live, 1'b1, (seen_q & ~live_q) == '0, "seen mark on a free slot")
	`RBBT_ASSERT_IMPL(a_pend_freed, cmd.fin_emit, (pend_q & live_q) == '0, "closing slot still live")
	`RBBT_ASSERT_NEXT(a_fin_last, cmd.fin_emit && !sts.more, result_strobe && result.last,
		"final close step without last result")
	`RBBT_ASSERT_NEXT(a_drop_res, drop,
		result_strobe && result.last && (result.status == rbbt_pkg::ST_DROP),
		"dropped run without status result")

endmodule

### sim/run_blob_bounding_box_tracker_tb.sv
// Self-checking testbench for the run-length blob bounding-box tracker.
`timescale 1ns / 100ps

module tb;

	// The opcode value that the block accepts and then ignores.
	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int TOTAL_ITEMS = 440;
	localparam int MAX_REPORTS  = 10;
	// Drain allowance covering the longest close sequence over all slots, with margin.
	localparam int DRAIN_CYCLES = 2 * rbbt_pkg::SLOTS + 8;

	typedef struct {
		rbbt_pkg::req_t rq;
		bit             typed;
		rbbt_pkg::res_t want;
	} step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	rbbt_pkg::req_t request = '0;
	rbbt_pkg::res_t result;
	logic result_strobe;

	// Typed expectation carried along with the request that it belongs to.
	logic item_typed = 1'b0;
	rbbt_pkg::res_t item_want = '0;

	// Copy of the slot table kept by the testbench.
	bit               blob_live [rbbt_pkg::SLOTS];
	bit               blob_seen [rbbt_pkg::SLOTS];
	rbbt_pkg::coord_t blob_first_row [rbbt_pkg::SLOTS];
	rbbt_pkg::coord_t blob_left [rbbt_pkg::SLOTS];
	rbbt_pkg::coord_t blob_right [rbbt_pkg::SLOTS];

	rbbt_pkg::res_t expected_boxes [$];
	int    n_mismatch = 0;
	int    items_sent = 0;
	bit    no_gaps = 1'b0;
	step_t directed [$];

	run_blob_bounding_box_tracker_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.request       (request),
		.result        (result),
		.result_strobe (result_strobe)
	);

	always #5 clk = ~clk;

	// Appends one expected result behind those already waiting.
	function automatic void expect_res(rbbt_pkg::res_t r);
		expected_boxes.insert(expected_boxes.size(), r);
	endfunction

	// Works out the results of one transaction and updates the slot table copy.
	function automatic void update_blob_table(rbbt_pkg::req_t rq);
		bit   hit;
		bit   opened;
		int   closed;
		int   i;
		rbbt_pkg::res_t r;
		hit = 1'b0;
		opened = 1'b0;
		closed = 0;
		r = '0;
		case (rq.opcode)
			rbbt_pkg::OP_RUN: begin
				for (i = 0; i < rbbt_pkg::SLOTS; i++) begin
					if (blob_live[i] && !(blob_left[i] > rq.col_end ||
							blob_right[i] < rq.col_start)) begin
						if (blob_left[i] > rq.col_start)
							blob_left[i] = rq.col_start;
						if (blob_right[i] < rq.col_end)
							blob_right[i] = rq.col_end;
						blob_seen[i] = 1'b1;
						hit = 1'b1;
					end
				end
				// A run touching nothing opens the lowest free slot, if any.
				for (i = 0; i < rbbt_pkg::SLOTS && !hit && !opened; i++) begin
					if (!blob_live[i]) begin
						blob_live[i] = 1'b1;
						blob_seen[i] = 1'b1;
						blob_first_row[i] = rq.row;
						blob_left[i] = rq.col_start;
						blob_right[i] = rq.col_end;
						opened = 1'b1;
					end
				end
				if (!hit && !opened) begin
					r.status = rbbt_pkg::ST_DROP;
					r.last = 1'b1;
					expect_res(r);
				end
			end
			rbbt_pkg::OP_FINISH: begin
				for (i = 0; i < rbbt_pkg::SLOTS; i++) begin
					if (blob_live[i] && !blob_seen[i]) begin
						r = '0;
						r.status = rbbt_pkg::ST_BOX;
						r.box_x = blob_left[i];
						r.box_y = blob_first_row[i];
						r.box_width = (blob_right[i] >= blob_left[i]) ?
							blob_right[i] - blob_left[i] : '0;
						r.box_height = (rq.row >= blob_first_row[i]) ?
							rq.row - blob_first_row[i] : '0;
						expect_res(r);
						blob_live[i] = 1'b0;
						closed++;
					end else begin
						blob_seen[i] = 1'b0;
					end
				end
				if (closed == 0) begin
					r = '0;
					r.status = rbbt_pkg::ST_ROW_EMPTY;
					r.last = 1'b1;
					expect_res(r);
				end else begin
					r = expected_boxes.pop_back();
					r.last = 1'b1;
					expect_res(r);
				end
			end
			rbbt_pkg::OP_FRAME: begin
				for (i = 0; i < rbbt_pkg::SLOTS; i++) begin
					blob_live[i] = 1'b0;
					blob_seen[i] = 1'b0;
				end
			end
			default: ;
		endcase
	endfunction

	// Compares one result with the oldest expectation.
	function automatic void check_box(rbbt_pkg::res_t got);
		rbbt_pkg::res_t want;
		if (expected_boxes.size() == 0) begin
			if (n_mismatch < MAX_REPORTS)
				$display("%0t: unexpected result status=%0d x=%0d y=%0d w=%0d h=%0d last=%0d",
					$realtime, got.status, got.box_x, got.box_y, got.box_width,
					got.box_height, got.last);
			n_mismatch++;
		end else begin
			want = expected_boxes.pop_front();
			if (got.status !== want.status || got.box_x !== want.box_x ||
					got.box_y !== want.box_y || got.box_width !== want.box_width ||
					got.box_height !== want.box_height || got.last !== want.last) begin
				if (n_mismatch < MAX_REPORTS) begin
					$display("%0t: result mismatch: expected status=%0d x=%0d y=%0d w=%0d h=%0d last=%0d",
						$realtime, want.status, want.box_x, want.box_y, want.box_width,
						want.box_height, want.last);
					$display("    got status=%0d x=%0d y=%0d w=%0d h=%0d last=%0d",
						got.status, got.box_x, got.box_y, got.box_width, got.box_height,
						got.last);
				end
				n_mismatch++;
			end
		end
	endfunction

	// Results are checked first, then an accepted transaction is predicted.
	always @(posedge clk or negedge arst_n) begin
		int i;
		int depth;
		if (!arst_n) begin
			for (i = 0; i < rbbt_pkg::SLOTS; i++) begin
				blob_live[i] = 1'b0;
				blob_seen[i] = 1'b0;
			end
			expected_boxes.delete();
		end else begin
			if (result_strobe)
				check_box(result);
			if (start && !busy) begin
				depth = expected_boxes.size();
				update_blob_table(request);
				// Rows with an expectation typed in use it instead of the prediction.
				if (item_typed) begin
					while (expected_boxes.size() > depth)
						void'(expected_boxes.pop_back());
					expect_res(item_want);
				end
			end
		end
	end

	function automatic rbbt_pkg::req_t mk_req(logic [1:0] op, int r, int cs, int ce);
		rbbt_pkg::req_t rq;
		rq.opcode = rbbt_pkg::opcode_t'(op);
		rq.row = rbbt_pkg::coord_t'(r);
		rq.col_start = rbbt_pkg::coord_t'(cs);
		rq.col_end = rbbt_pkg::coord_t'(ce);
		return rq;
	endfunction

	function automatic step_t mk_step(logic [1:0] op, int r, int cs, int ce, bit typed,
			rbbt_pkg::status_t st);
		step_t s;
		s.rq = mk_req(op, r, cs, ce);
		s.typed = typed;
		s.want = '0;
		s.want.status = st;
		s.want.last = 1'b1;
		return s;
	endfunction

	// Appends one row to the directed table.
	function automatic void add_row(step_t s);
		directed.insert(directed.size(), s);
	endfunction

	// Offers one transaction until it is taken; start drops at random in some cycles.
	task automatic issue(rbbt_pkg::req_t rq, bit typed, rbbt_pkg::res_t want);
		bit offer;
		request <= rq;
		item_typed <= typed;
		item_want <= want;
		offer = no_gaps || ($urandom_range(99) >= 22);
		start <= offer;
		@(posedge clk);
		while (!(offer && !busy)) begin
			offer = no_gaps || ($urandom_range(99) >= 22);
			start <= offer;
			@(posedge clk);
		end
		items_sent++;
	endtask

	task automatic issue_plain(rbbt_pkg::req_t rq);
		issue(rq, 1'b0, '0);
	endtask

	// A few rows of overlapping runs in a narrow band, each row then finished.
	task automatic sweep_rows();
		int base;
		int r;
		int cs;
		int ce;
		int k;
		int j;
		if ($urandom_range(3) == 0)
			issue_plain(mk_req(rbbt_pkg::OP_FRAME, $urandom_range(4095), 0, 0));
		base = $urandom_range(4095);
		for (k = 0; k < $urandom_range(1, 6); k++) begin
			r = ($urandom_range(7) == 0) ? $urandom_range(4095) : base + k;
			for (j = 0; j < $urandom_range(0, 5); j++) begin
				cs = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(255);
				ce = cs + $urandom_range(40);
				if ($urandom_range(9) == 0)
					issue_plain(mk_req(rbbt_pkg::OP_RUN, r, ce, cs));
				else
					issue_plain(mk_req(rbbt_pkg::OP_RUN, r, cs, ce));
			end
			issue_plain(mk_req(rbbt_pkg::OP_FINISH, r, $urandom_range(4095),
				$urandom_range(4095)));
		end
	endtask

	// Many disjoint runs in one row, often enough to fill the table and drop some.
	task automatic flood_table();
		int r;
		int cs;
		int k;
		r = $urandom_range(4095);
		for (k = 0; k < $urandom_range(28, 40); k++) begin
			cs = k * 100 + $urandom_range(20);
			issue_plain(mk_req(rbbt_pkg::OP_RUN, r, cs, cs + $urandom_range(60)));
		end
		issue_plain(mk_req(rbbt_pkg::OP_FINISH, r, 0, 0));
		issue_plain(mk_req(rbbt_pkg::OP_FINISH, r + $urandom_range(1, 30), 0, 0));
	endtask

	// Stimulus: directed table first, then random scenarios.
	initial begin
		int pick;
		int drain;
		// Directed table: empty table, extremes, reversed runs, merges, frames.
		add_row(mk_step(rbbt_pkg::OP_FINISH, 0, 0, 0, 1'b1, rbbt_pkg::ST_ROW_EMPTY));
		add_row(mk_step(OP_SPARE, 4095, 4095, 4095, 1'b0, rbbt_pkg::ST_BOX));
		add_row(mk_step(rbbt_pkg::OP_RUN, 0, 0, 0, 1'b0, rbbt_pkg::ST_BOX));
		add_row(mk_step(rbbt_pkg::OP_RUN, 0, 4095, 4095, 1'b0, rbbt_pkg::ST_BOX));
		add_row(mk_step(rbbt_pkg::OP_RUN, 1, 10, 5, 1'b0, rbbt_pkg::ST_BOX));
		add_row(mk_step(rbbt_pkg::OP_FINISH, 1, 0, 0, 1'b1, rbbt_pkg::ST_ROW_EMPTY));
		add_row(mk_step(rbbt_pkg::OP_FINISH, 4095, 0, 0, 1'b0, rbbt_pkg::ST_BOX));
		add_row(mk_step(rbbt_pkg::OP_RUN, 4095, 100, 200, 1'b0, rbbt_pkg::ST_BOX));
		add_row(mk_step(rbbt_pkg::OP_RUN, 4095, 300, 400, 1'b0, rbbt_pkg::ST_BOX));
		add_row(mk_step(rbbt_pkg::OP_RUN, 4095, 150, 350, 1'b0, rbbt_pkg::ST_BOX));
		add_row(mk_step(rbbt_pkg::OP_FINISH, 4095, 0, 0, 1'b1, rbbt_pkg::ST_ROW_EMPTY));
		add_row(mk_step(rbbt_pkg::OP_FINISH, 0, 0, 0, 1'b0, rbbt_pkg::ST_BOX));
		add_row(mk_step(rbbt_pkg::OP_RUN, 5, 0, 4095, 1'b0, rbbt_pkg::ST_BOX));
		add_row(mk_step(rbbt_pkg::OP_FRAME, 0, 0, 0, 1'b0, rbbt_pkg::ST_BOX));
		add_row(mk_step(rbbt_pkg::OP_FINISH, 6, 0, 0, 1'b1, rbbt_pkg::ST_ROW_EMPTY));
		add_row(mk_step(rbbt_pkg::OP_RUN, 7, 20, 30, 1'b0, rbbt_pkg::ST_BOX));
		add_row(mk_step(rbbt_pkg::OP_RUN, 7, 40, 50, 1'b0, rbbt_pkg::ST_BOX));
		add_row(mk_step(rbbt_pkg::OP_RUN, 8, 25, 45, 1'b0, rbbt_pkg::ST_BOX));
		add_row(mk_step(rbbt_pkg::OP_FINISH, 8, 0, 0, 1'b1, rbbt_pkg::ST_ROW_EMPTY));
		add_row(mk_step(rbbt_pkg::OP_FINISH, 9, 0, 0, 1'b0, rbbt_pkg::ST_BOX));
		add_row(mk_step(rbbt_pkg::OP_FRAME, 4095, 4095, 4095, 1'b0, rbbt_pkg::ST_BOX));
		add_row(mk_step(rbbt_pkg::OP_RUN, 0, 0, 4095, 1'b0, rbbt_pkg::ST_BOX));
		add_row(mk_step(rbbt_pkg::OP_FINISH, 0, 0, 0, 1'b1, rbbt_pkg::ST_ROW_EMPTY));
		add_row(mk_step(rbbt_pkg::OP_FINISH, 4095, 0, 0, 1'b0, rbbt_pkg::ST_BOX));

		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[k])
			issue(directed[k].rq, directed[k].typed, directed[k].want);

		// Random part, with a stretch in the middle that has no gaps at all.
		while (items_sent < TOTAL_ITEMS) begin
			no_gaps = (items_sent >= 200 && items_sent < 300);
			pick = $urandom_range(99);
			if (pick < 72)
				sweep_rows();
			else if (pick < 80)
				flood_table();
			else
				issue_plain(mk_req(2'($urandom_range(3)), $urandom_range(4095),
					$urandom_range(4095), $urandom_range(4095)));
		end

		// Let the last results drain before judging the run.
		start <= 1'b0;
		drain = 0;
		while (expected_boxes.size() != 0 && drain < 2000) begin
			@(posedge clk);
			drain++;
		end
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (expected_boxes.size() != 0) begin
			$display("%0d expected results never arrived", expected_boxes.size());
			n_mismatch += expected_boxes.size();
		end
		if (n_mismatch == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

### files.f
+incdir+sv
sv/rbbt_pkg.sv
sv/rbbt_ctrl.sv
sv/rbbt_datapath.sv
sv/run_blob_bounding_box_tracker_top.sv
sim/run_blob_bounding_box_tracker_tb.sv
